/* hw/rtl/i2cseq_pkg.sv */
// ----------------------------------------------------------------------------
// I2C sequencer package
// Shared types and constants for the write-then-read transaction sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

    localparam int TX_DEPTH = 16;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);

    // input operations
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_DONE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;
    localparam logic [1:0] KIND_BUSY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_AL   = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;

    // core register selects
    localparam logic [2:0] SEL_PRER_LO = 3'd0;
    localparam logic [2:0] SEL_PRER_HI = 3'd1;
    localparam logic [2:0] SEL_CTR = 3'd2;
    localparam logic [2:0] SEL_TXR = 3'd3;
    localparam logic [2:0] SEL_CR  = 3'd4;
    localparam logic [2:0] SEL_SR  = 3'd5;
    localparam logic [2:0] SEL_RXR = 3'd6;

    // core bits
    localparam logic [7:0] CTR_EN   = 8'h80;
    localparam logic [7:0] CR_STA   = 8'h80;
    localparam logic [7:0] CR_STO   = 8'h40;
    localparam logic [7:0] CR_RD    = 8'h20;
    localparam logic [7:0] CR_WR    = 8'h10;
    localparam logic [7:0] CR_ACK   = 8'h08;
    localparam int         SR_RXACK = 7;
    localparam int         SR_AL    = 5;
    localparam int         SR_TIP   = 1;

    // one request held in the queue
    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] device_address;
        logic [4:0] tx_count;
        logic [7:0] rx_count;
        logic [7:0] tx_byte;
        logic [7:0] access_data;
    } req_t;

    // one result
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_select;
        logic       is_read;
        logic [7:0] wr_byte;
        logic [7:0] rx_byte;
        logic [1:0] status;
    } res_t;

    function automatic res_t acc_w(input logic [2:0] sel, input logic [7:0] d);
        res_t r;
        r = '0;
        r.kind = KIND_ACC;
        r.reg_select = sel;
        r.wr_byte = d;
        return r;
    endfunction

    function automatic res_t acc_r(input logic [2:0] sel);
        res_t r;
        r = '0;
        r.kind = KIND_ACC;
        r.reg_select = sel;
        r.is_read = 1'b1;
        return r;
    endfunction

endpackage

/* hw/rtl/i2cseq_queue.sv */
// ----------------------------------------------------------------------------
// I2C sequencer request queue
// Two-entry queue between the front end and the sequencing back end.
// ----------------------------------------------------------------------------
module i2cseq_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  i2cseq_pkg::req_t   wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output i2cseq_pkg::req_t   rd_data
);

    i2cseq_pkg::req_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill update
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue overfilled");
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2) else $error("queue lost entry");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !push) |=> !rd_valid) else $error("queue invented entry");
`endif

endmodule

/* hw/rtl/i2cseq_engine.sv */
// ----------------------------------------------------------------------------
// I2C sequencer engine
// Back end: takes queued requests, keeps transaction state and emits up to two
// results per request, one per cycle unless stalled, via an output register.
// ----------------------------------------------------------------------------
module i2cseq_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       prescale_value,
    input  logic              req_valid,
    output logic              req_ready,
    input  i2cseq_pkg::req_t  req,
    output logic              m_valid,
    input  logic              m_ready,
    output i2cseq_pkg::res_t  m_res,
    output logic              m_last
);

    typedef enum logic [10:0] {
        S_RESET     = 11'b00000000001,
        S_INIT_A    = 11'b00000000010,
        S_INIT_B    = 11'b00000000100,
        S_IDLE      = 11'b00000001000,
        S_SEND      = 11'b00000010000,
        S_SEND_WAIT = 11'b00000100000,
        S_RECV      = 11'b00001000000,
        S_RECV_WAIT = 11'b00010000000,
        S_RECV_DATA = 11'b00100000000,
        S_STOP      = 11'b01000000000,
        S_STOP_WAIT = 11'b10000000000
    } seq_t;

    seq_t seq_reg, seq_next;
    logic [7:0] tx_store_reg [i2cseq_pkg::TX_DEPTH];
    logic [i2cseq_pkg::TX_CW-1:0] rptr_reg, rptr_next, lptr_reg, lptr_next;
    logic [i2cseq_pkg::TX_CW-1:0] txl_reg, txl_next;
    logic [7:0] rxl_reg, rxl_next;
    logic       two_reg, two_next;
    logic [6:0] addr_reg, addr_next;
    logic [1:0] lres_reg, lres_next;
    logic [1:0] outs_reg, outs_next;

    // pending result slots (up to three) and the output register
    i2cseq_pkg::res_t pend_reg [3];
    i2cseq_pkg::res_t pend_next [3];
    logic [1:0] pn_reg, pn_next;       // results still to send
    logic [1:0] pi_reg, pi_next;       // next slot to send
    logic       ov_reg, ov_next, ol_reg, ol_next;
    i2cseq_pkg::res_t od_reg, od_next;

    logic       take, load_en, out_free;
    logic [1:0] n;
    logic [7:0] txb, cmd, d;
    logic [4:0] tc;
    logic [7:0] rx_after;

    assign out_free  = !ov_reg || m_ready;
    assign req_ready = (pn_reg == 2'd0);
    assign take      = req_valid && req_ready;
    assign m_valid   = ov_reg;
    assign m_res     = od_reg;
    assign m_last    = ol_reg;
    assign d         = req.access_data;
    assign txb       = (rptr_reg < i2cseq_pkg::TX_CW'(i2cseq_pkg::TX_DEPTH)) ?
                       tx_store_reg[rptr_reg[i2cseq_pkg::TX_AW-1:0]] : 8'h00;
    assign tc        = (req.tx_count > 5'(i2cseq_pkg::TX_DEPTH)) ?
                       5'(i2cseq_pkg::TX_DEPTH) : req.tx_count;
    assign rx_after  = (rxl_reg != 8'd0) ? rxl_reg - 8'd1 : 8'd0;

    // request decode and transaction sequencing
    always_comb begin
        seq_next  = seq_reg;
        rptr_next = rptr_reg;
        lptr_next = lptr_reg;
        txl_next  = txl_reg;
        rxl_next  = rxl_reg;
        two_next  = two_reg;
        addr_next = addr_reg;
        lres_next = lres_reg;
        outs_next = outs_reg;
        load_en   = 1'b0;
        cmd       = 8'h00;
        n         = 2'd0;
        for (int i = 0; i < 3; i++) pend_next[i] = pend_reg[i];
        if (take) begin
            for (int i = 0; i < 3; i++) pend_next[i] = '0;
            unique case (req.operation)
                i2cseq_pkg::OP_INIT: begin
                    if (outs_reg == 2'd0) begin
                        pend_next[0] = i2cseq_pkg::acc_w(i2cseq_pkg::SEL_CTR, 8'h00);
                        pend_next[1] = i2cseq_pkg::acc_w(i2cseq_pkg::SEL_PRER_LO,
                                                         prescale_value[7:0]);
                        n = 2'd2;
                        seq_next = S_INIT_A;
                    end
                end
                i2cseq_pkg::OP_LOAD: begin
                    if ((seq_reg == S_IDLE || seq_reg == S_RESET) &&
                        lptr_reg < i2cseq_pkg::TX_CW'(i2cseq_pkg::TX_DEPTH)) begin
                        load_en   = 1'b1;
                        lptr_next = lptr_reg + 1'b1;
                    end
                end
                i2cseq_pkg::OP_START: begin
                    if (seq_reg != S_IDLE) begin
                        pend_next[0].kind   = i2cseq_pkg::KIND_BUSY;
                        pend_next[0].status = i2cseq_pkg::ST_BUSY;
                        n = 2'd1;
                    end else begin
                        addr_next = req.device_address;
                        txl_next  = i2cseq_pkg::TX_CW'(tc);
                        rxl_next  = req.rx_count;
                        rptr_next = '0;
                        lptr_next = '0;
                        two_next  = (tc != 5'd0) && (req.rx_count != 8'd0);
                        seq_next  = S_SEND;
                        pend_next[0] = i2cseq_pkg::acc_w(i2cseq_pkg::SEL_TXR,
                            {req.device_address, (tc == 5'd0)});
                        pend_next[1] = i2cseq_pkg::acc_w(i2cseq_pkg::SEL_CR,
                            i2cseq_pkg::CR_STA | i2cseq_pkg::CR_WR);
                        n = 2'd2;
                    end
                end
                i2cseq_pkg::OP_DONE: begin
                    if (outs_reg != 2'd0) begin
                        outs_next = outs_reg - 2'd1;
                        if (outs_reg == 2'd1) begin
                            priority case (1'b1)
                                seq_reg == S_INIT_A: begin
                                    pend_next[0] = i2cseq_pkg::acc_w(
                                        i2cseq_pkg::SEL_PRER_HI, prescale_value[15:8]);
                                    pend_next[1] = i2cseq_pkg::acc_w(
                                        i2cseq_pkg::SEL_CTR, i2cseq_pkg::CTR_EN);
                                    n = 2'd2;
                                    seq_next = S_INIT_B;
                                end
                                seq_reg == S_INIT_B: seq_next = S_IDLE;
                                seq_reg == S_SEND || seq_reg == S_RECV ||
                                seq_reg == S_STOP: begin
                                    pend_next[0] = i2cseq_pkg::acc_r(i2cseq_pkg::SEL_SR);
                                    n = 2'd1;
                                    seq_next = (seq_reg == S_SEND) ? S_SEND_WAIT :
                                               (seq_reg == S_RECV) ? S_RECV_WAIT :
                                               S_STOP_WAIT;
                                end
                                seq_reg == S_SEND_WAIT: begin
                                    n = 2'd1;
                                    if (d[i2cseq_pkg::SR_TIP]) begin
                                        pend_next[0] = i2cseq_pkg::acc_r(i2cseq_pkg::SEL_SR);
                                    end else if (d[i2cseq_pkg::SR_AL]) begin
                                        pend_next[0].kind   = i2cseq_pkg::KIND_FIN;
                                        pend_next[0].status = i2cseq_pkg::ST_AL;
                                        lres_next = i2cseq_pkg::ST_AL;
                                        seq_next  = S_IDLE;
                                    end else if (d[i2cseq_pkg::SR_RXACK]) begin
                                        lres_next = i2cseq_pkg::ST_NACK;
                                        pend_next[0] = i2cseq_pkg::acc_w(i2cseq_pkg::SEL_CR,
                                                                         i2cseq_pkg::CR_STO);
                                        seq_next = S_STOP;
                                    end else if (txl_reg != '0) begin
                                        rptr_next = rptr_reg + 1'b1;
                                        txl_next  = txl_reg - 1'b1;
                                        cmd = i2cseq_pkg::CR_WR;
                                        if (txl_reg == i2cseq_pkg::TX_CW'(1) &&
                                            rxl_reg == 8'd0) begin
                                            cmd = cmd | i2cseq_pkg::CR_STO;
                                        end
                                        pend_next[0] = i2cseq_pkg::acc_w(
                                            i2cseq_pkg::SEL_TXR, txb);
                                        pend_next[1] = i2cseq_pkg::acc_w(
                                            i2cseq_pkg::SEL_CR, cmd);
                                        n = 2'd2;
                                        seq_next = S_SEND;
                                    end else if (rxl_reg != 8'd0) begin
                                        if (two_reg) begin
                                            pend_next[0] = i2cseq_pkg::acc_w(
                                                i2cseq_pkg::SEL_TXR, {addr_reg, 1'b1});
                                            pend_next[1] = i2cseq_pkg::acc_w(
                                                i2cseq_pkg::SEL_CR,
                                                i2cseq_pkg::CR_STA | i2cseq_pkg::CR_WR);
                                            n = 2'd2;
                                            two_next = 1'b0;
                                            seq_next = S_SEND;
                                        end else begin
                                            cmd = i2cseq_pkg::CR_RD;
                                            if (rxl_reg == 8'd1) begin
                                                cmd = cmd | i2cseq_pkg::CR_ACK |
                                                      i2cseq_pkg::CR_STO;
                                            end
                                            pend_next[0] = i2cseq_pkg::acc_w(
                                                i2cseq_pkg::SEL_CR, cmd);
                                            seq_next = S_RECV;
                                        end
                                    end else begin
                                        pend_next[0].kind = i2cseq_pkg::KIND_FIN;
                                        lres_next = i2cseq_pkg::ST_OK;
                                        seq_next  = S_IDLE;
                                    end
                                end
                                seq_reg == S_RECV_WAIT: begin
                                    n = 2'd1;
                                    if (d[i2cseq_pkg::SR_TIP]) begin
                                        pend_next[0] = i2cseq_pkg::acc_r(i2cseq_pkg::SEL_SR);
                                    end else begin
                                        pend_next[0] = i2cseq_pkg::acc_r(i2cseq_pkg::SEL_RXR);
                                        seq_next = S_RECV_DATA;
                                    end
                                end
                                seq_reg == S_RECV_DATA: begin
                                    pend_next[0].kind    = i2cseq_pkg::KIND_RX;
                                    pend_next[0].rx_byte = d;
                                    n = 2'd2;
                                    rxl_next = rx_after;
                                    if (rx_after == 8'd0) begin
                                        pend_next[1].kind = i2cseq_pkg::KIND_FIN;
                                        lres_next = i2cseq_pkg::ST_OK;
                                        seq_next  = S_IDLE;
                                    end else begin
                                        cmd = i2cseq_pkg::CR_RD;
                                        if (rx_after == 8'd1) begin
                                            cmd = cmd | i2cseq_pkg::CR_ACK |
                                                  i2cseq_pkg::CR_STO;
                                        end
                                        pend_next[1] = i2cseq_pkg::acc_w(
                                            i2cseq_pkg::SEL_CR, cmd);
                                        seq_next = S_RECV;
                                    end
                                end
                                seq_reg == S_STOP_WAIT: begin
                                    n = 2'd1;
                                    if (d[i2cseq_pkg::SR_TIP]) begin
                                        pend_next[0] = i2cseq_pkg::acc_r(i2cseq_pkg::SEL_SR);
                                    end else begin
                                        pend_next[0].kind   = i2cseq_pkg::KIND_FIN;
                                        pend_next[0].status = lres_reg;
                                        seq_next = S_IDLE;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
            // count accesses issued by this request
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n && pend_next[i].kind == i2cseq_pkg::KIND_ACC) begin
                    outs_next = outs_next + 2'd1;
                end
            end
        end
    end

    // result emission, one per cycle unless the output stalls
    always_comb begin
        pn_next = take ? n : pn_reg;
        pi_next = take ? 2'd0 : pi_reg;
        ov_next = out_free ? 1'b0 : ov_reg;
        ol_next = ol_reg;
        od_next = od_reg;
        if (out_free && pn_reg != 2'd0) begin
            ov_next = 1'b1;
            od_next = pend_reg[pi_reg];
            ol_next = (pn_reg == 2'd1);
            pn_next = pn_reg - 2'd1;
            pi_next = pi_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg  <= S_RESET;
            rptr_reg <= '0;
            lptr_reg <= '0;
            txl_reg  <= '0;
            rxl_reg  <= '0;
            two_reg  <= 1'b0;
            addr_reg <= '0;
            lres_reg <= i2cseq_pkg::ST_OK;
            outs_reg <= '0;
            pn_reg   <= '0;
            pi_reg   <= '0;
            ov_reg   <= 1'b0;
        end else begin
            seq_reg  <= seq_next;
            rptr_reg <= rptr_next;
            lptr_reg <= lptr_next;
            txl_reg  <= txl_next;
            rxl_reg  <= rxl_next;
            two_reg  <= two_next;
            addr_reg <= addr_next;
            lres_reg <= lres_next;
            outs_reg <= outs_next;
            pn_reg   <= pn_next;
            pi_reg   <= pi_next;
            ov_reg   <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) pend_reg[i] <= pend_next[i];
        od_reg <= od_next;
        ol_reg <= ol_next;
        if (load_en) begin
            tx_store_reg[lptr_reg[i2cseq_pkg::TX_AW-1:0]] <= req.tx_byte;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(od_reg)) else $error("result dropped");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (pn_reg != 2'd0) |-> !req_ready) else $error("request taken while busy");
    a_pend_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pn_reg != 2'd3) else $error("too many pending results");
`endif

endmodule

/* hw/rtl/i2c_core_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C core transaction sequencer
// Sequences write-then-read transactions on a register-mapped I2C master core.
// ----------------------------------------------------------------------------
// Flow: a request accepted into the queue is taken by the back end, which
// places its results in pending slots and sends each via the output register.
// Throughput: one result per cycle unless m_ready stalls the output, set by
// the single result port; a new request is taken once prior results are sent.
// A two-entry queue decouples input acceptance from result emission.
// Reset: synchronous, active low; sequencer awaits init, prescaler is 3.
module i2c_core_transaction_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [6:0]  s_device_address,
    input  logic [4:0]  s_tx_count,
    input  logic [7:0]  s_rx_count,
    input  logic [7:0]  s_tx_byte,
    input  logic [7:0]  s_access_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_reg_select,
    output logic        m_is_read,
    output logic [7:0]  m_wr_byte,
    output logic [7:0]  m_rx_byte,
    output logic [1:0]  m_status,
    output logic        m_last
);

    logic [15:0]       prescale_reg;
    i2cseq_pkg::req_t  in_req, q_req;
    i2cseq_pkg::res_t  res;
    logic              q_valid, q_ready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= 16'd3;
        end else if (cfg_wr_en) begin
            prescale_reg <= cfg_wr_data;
        end
    end

    assign in_req = '{operation: s_operation, device_address: s_device_address,
                      tx_count: s_tx_count, rx_count: s_rx_count,
                      tx_byte: s_tx_byte, access_data: s_access_data};

    i2cseq_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(in_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    i2cseq_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .prescale_value(prescale_reg),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(res), .m_last(m_last)
    );

    assign m_kind       = res.kind;
    assign m_reg_select = res.reg_select;
    assign m_is_read    = res.is_read;
    assign m_wr_byte    = res.wr_byte;
    assign m_rx_byte    = res.rx_byte;
    assign m_status     = res.status;

endmodule
